[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/ipst_pkg.sv]
`default_nettype none
package ipst_pkg;

    // Table depth default
    localparam int NUM_ENTRIES_DEF = 32;

    // Field widths
    localparam int FUNC_W     = 3;
    localparam int ENTRY_W    = 5;
    localparam int TIME_W     = 64;
    localparam int CYC_W      = 32;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 64;
    localparam int ACTIVE_W   = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 8'd1;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_START  = 3'd0,
        FUNC_END    = 3'd1,
        FUNC_REJECT = 3'd2,
        FUNC_CLEAR  = 3'd3,
        FUNC_READ   = 3'd4
    } func_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic calc;
        logic update;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

[sv/ipst_ctrl.sv]
`default_nettype none
module ipst_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ipst_pkg::sts_t sts,
    output ipst_pkg::cmd_t     cmd
);
    import ipst_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CALC   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence one transaction: capture and read, subtract, accumulate
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.calc    = 1'b0;
        cmd.update  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // hold until the output register can take the result
                if (!sts.out_busy)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[sv/ipst_datapath.sv]
`default_nettype none
module ipst_datapath #(
    parameter int NUM_ENTRIES = ipst_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ipst_pkg::cmd_t                   cmd,
    output ipst_pkg::sts_t                        sts,
    input  wire logic [ipst_pkg::FUNC_W-1:0]      func,
    input  wire logic [ipst_pkg::ENTRY_W-1:0]     entry,
    input  wire logic [ipst_pkg::TIME_W-1:0]      time_us,
    input  wire logic [ipst_pkg::CYC_W-1:0]       cycle_stamp,
    input  wire logic                             cfg_valid,
    input  wire logic [ipst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ipst_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  status,
    output logic                                  busy_res,
    output logic [ipst_pkg::CNT_W-1:0]            calls,
    output logic [ipst_pkg::SUM_W-1:0]            total_time,
    output logic [ipst_pkg::SUM_W-1:0]            cycle_total,
    output logic [ipst_pkg::TIME_W-1:0]           min_time,
    output logic [ipst_pkg::TIME_W-1:0]           max_time,
    output logic [ipst_pkg::CNT_W-1:0]            rejections
);
    import ipst_pkg::*;

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [CYC_W-1:0]  c;
    } start_t;

    typedef struct packed {
        logic [CNT_W-1:0]  calls;
        logic [SUM_W-1:0]  tsum;
        logic [SUM_W-1:0]  csum;
        logic [TIME_W-1:0] tmin;
        logic [TIME_W-1:0] tmax;
    } stat_t;

    localparam stat_t STAT_RESET = '{calls: '0, tsum: '0, csum: '0, tmin: '1, tmax: '0};

    // Entry storage; stats entries not yet valid read as their reset value
    start_t start_mem [NUM_ENTRIES];
    stat_t  stat_mem  [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] stat_valid_reg;
    logic [NUM_ENTRIES-1:0] busy_vec_reg;

    // Configuration
    logic                enable_reg;
    logic [ACTIVE_W-1:0] active_reg;

    // Captured transaction
    logic [FUNC_W-1:0]  func_reg;
    logic [IDX_W-1:0]   addr_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [CYC_W-1:0]   cyc_reg;
    logic               in_table_reg;
    logic               lim_ok_reg;
    logic               ent_valid_reg;
    logic               busy_reg;
    start_t             rd_start_reg;
    stat_t              rd_stat_reg;

    // Decision and difference stage
    logic [TIME_W-1:0]  el_us_reg;
    logic [CYC_W-1:0]   el_cyc_reg;
    logic               do_start_reg;
    logic               do_end_reg;
    logic               do_rej_reg;
    logic               do_clear_reg;
    logic               status_reg;

    logic               out_valid_reg;
    logic [CNT_W-1:0]   rej_reg;

    logic [IDX_W-1:0]   addr_in;
    logic               in_table_in;
    stat_t              cur;
    stat_t              upd;
    stat_t              res;
    logic [CNT_W-1:0]   rej_next;
    logic               do_start_next;
    logic               do_end_next;
    logic               do_rej_next;
    logic               do_clear_next;
    logic               status_next;
    logic               busy_out;

    assign addr_in     = IDX_W'(entry);
    assign in_table_in = (32'(entry) < 32'(NUM_ENTRIES));

    // Capture the transaction and read the addressed entry
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg      <= func;
            addr_reg      <= addr_in;
            time_reg      <= time_us;
            cyc_reg       <= cycle_stamp;
            in_table_reg  <= in_table_in;
            lim_ok_reg    <= in_table_in && ({1'b0, entry} < active_reg);
            ent_valid_reg <= in_table_in && stat_valid_reg[addr_in];
            busy_reg      <= in_table_in && busy_vec_reg[addr_in];
            rd_start_reg  <= start_mem[addr_in];
            rd_stat_reg   <= stat_mem[addr_in];
        end
    end

    assign cur = ent_valid_reg ? rd_stat_reg : STAT_RESET;

    // Decide what the operation does
    always_comb
    begin
        do_start_next = 1'b0;
        do_end_next   = 1'b0;
        do_rej_next   = 1'b0;
        do_clear_next = 1'b0;
        status_next   = 1'b1;
        case (func_reg)
            FUNC_START:
            begin
                do_start_next = enable_reg && lim_ok_reg && !busy_reg;
                status_next   = !do_start_next;
            end
            FUNC_END:
            begin
                do_end_next = enable_reg && lim_ok_reg && busy_reg;
                status_next = !do_end_next;
            end
            FUNC_REJECT:
            begin
                do_rej_next = enable_reg;
                status_next = !enable_reg;
            end
            FUNC_CLEAR:
            begin
                do_clear_next = 1'b1;
                status_next   = 1'b0;
            end
            FUNC_READ:
            begin
                status_next = !lim_ok_reg;
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    // Work out elapsed time and cycles
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            el_us_reg    <= time_reg - rd_start_reg.t;
            el_cyc_reg   <= cyc_reg - rd_start_reg.c;
            do_start_reg <= do_start_next;
            do_end_reg   <= do_end_next;
            do_rej_reg   <= do_rej_next;
            do_clear_reg <= do_clear_next;
            status_reg   <= status_next;
        end
    end

    // Accumulate into the entry
    always_comb
    begin
        upd.calls = cur.calls + CNT_W'(1);
        upd.tsum  = cur.tsum + el_us_reg;
        upd.csum  = cur.csum + SUM_W'(el_cyc_reg);
        upd.tmin  = (el_us_reg < cur.tmin) ? el_us_reg : cur.tmin;
        upd.tmax  = (el_us_reg > cur.tmax) ? el_us_reg : cur.tmax;
    end

    always_comb
    begin
        if (do_clear_reg)
        begin
            res      = STAT_RESET;
            busy_out = 1'b0;
            rej_next = '0;
        end
        else
        begin
            res      = do_end_reg ? upd : cur;
            busy_out = do_start_reg || (busy_reg && !do_end_reg);
            rej_next = do_rej_reg ? rej_reg + CNT_W'(1) : rej_reg;
        end
    end

    // Write back the entry storage
    always_ff @(posedge clk)
    begin
        if (cmd.update && do_end_reg)
        begin
            stat_mem[addr_reg] <= upd;
        end
        if (cmd.update && do_start_reg)
        begin
            start_mem[addr_reg] <= '{t: time_reg, c: cyc_reg};
        end
    end

    // Valid, busy and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_valid_reg <= '0;
            busy_vec_reg   <= '0;
            rej_reg        <= '0;
            enable_reg     <= 1'b0;
            active_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_ENABLE))
            begin
                enable_reg <= cfg_data[0];
            end
            if (cfg_valid && (cfg_index == CFG_ACTIVE))
            begin
                active_reg <= cfg_data[ACTIVE_W-1:0];
            end
            if (cmd.update)
            begin
                rej_reg <= rej_next;
                if (do_clear_reg)
                begin
                    stat_valid_reg <= '0;
                    busy_vec_reg   <= '0;
                end
                else if (do_end_reg)
                begin
                    stat_valid_reg[addr_reg] <= 1'b1;
                    busy_vec_reg[addr_reg]   <= 1'b0;
                end
                else if (do_start_reg)
                begin
                    busy_vec_reg[addr_reg] <= 1'b1;
                end
            end
            // drop the result once taken, load a new one on update
            if (cmd.update)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            status      <= status_reg;
            busy_res    <= busy_out;
            calls       <= res.calls;
            total_time  <= res.tsum;
            cycle_total <= res.csum;
            min_time    <= res.tmin;
            max_time    <= res.tmax;
            rejections  <= rej_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

endmodule
`default_nettype wire

[sv/interval_profile_stats_table.sv]
// Interval profiling statistics table.
// Input channel (in_valid/in_ready) carries func, entry, time_us and
// cycle_stamp; every transaction yields exactly one result transaction on
// the output channel (out_valid/out_ready) showing the addressed entry
// after the operation and the global rejection count.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready: index 0 is enable, index 1 is the number of active entries.
// The result enters the output register in the accumulate and write-back
// stage, once that register is free. A new transaction is accepted only
// after the previous one has passed in turn the registered entry read, the
// subtract stage, then the accumulate and write-back stage, on one entry port.
// Reset clears enable, the active count, all entries (per-entry valid bits)
// and the rejection counter at once; no clearing pass is needed.
// When the receiver stalls the result is held; one more transaction is
// accepted and waits in its final stage until the output register frees.
`default_nettype none
module interval_profile_stats_table #(
    parameter int NUM_ENTRIES = ipst_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [ipst_pkg::FUNC_W-1:0]      func,
    input  wire logic [ipst_pkg::ENTRY_W-1:0]     entry,
    input  wire logic [ipst_pkg::TIME_W-1:0]      time_us,
    input  wire logic [ipst_pkg::CYC_W-1:0]       cycle_stamp,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  status,
    output logic                                  busy_res,
    output logic [ipst_pkg::CNT_W-1:0]            calls,
    output logic [ipst_pkg::SUM_W-1:0]            total_time,
    output logic [ipst_pkg::SUM_W-1:0]            cycle_total,
    output logic [ipst_pkg::TIME_W-1:0]           min_time,
    output logic [ipst_pkg::TIME_W-1:0]           max_time,
    output logic [ipst_pkg::CNT_W-1:0]            rejections,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ipst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ipst_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ipst_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Register writes are taken in any cycle
    assign cfg_ready = 1'b1;

    ipst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipst_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .entry       (entry),
        .time_us     (time_us),
        .cycle_stamp (cycle_stamp),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .busy_res    (busy_res),
        .calls       (calls),
        .total_time  (total_time),
        .cycle_total (cycle_total),
        .min_time    (min_time),
        .max_time    (max_time),
        .rejections  (rejections)
    );

endmodule
`default_nettype wire

[sv/ipst_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module ipst_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [ipst_pkg::TIME_W-1:0]      min_time,
    input wire logic [ipst_pkg::TIME_W-1:0]      max_time
);
    import ipst_pkg::*;

    logic in_acc;
    logic out_stall;
    logic range_ok;

    assign in_acc    = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign range_ok  = (min_time <= max_time) || ((min_time == '1) && (max_time == '0));

    // A stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)

    // One transaction at a time: in_ready stays low through the calc state and the first update cycle
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ready ##1 !in_ready)

    // Minimum never exceeds maximum unless the entry has no interval yet
    `ASSERT_IMPLY(a_min_max, clk, rst_n, out_valid, range_ok)

endmodule

bind interval_profile_stats_table ipst_checker u_ipst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_time  (min_time),
    .max_time  (max_time)
);
`default_nettype wire
